// ----- rtl/ssimps_pkg.sv -----
`timescale 1ns / 1ps
// ssimps_pkg: constants, types and helper functions shared by the plane ssim scorer
// depends on nothing; used by the controller, datapath, interfaces and top level

package ssimps_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int WINDOW      = 8;
   localparam int WIN_LOG     = 3;
   localparam int NCOLS       = MAX_WIDTH / WINDOW;
   localparam int COL_AW      = $clog2(NCOLS);
   localparam int POS_W       = 12;
   localparam int DIM_W       = 13;
   localparam int DEPTH_W     = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int SAMPLE_W    = 12;
   localparam int FRAC_BITS   = 16;
   localparam int SUM_W       = 18;
   localparam int SQ_W        = 30;
   localparam int PAIR_W      = 36;
   localparam int VAR_W       = 37;
   localparam int K_W         = 37;
   localparam int K9_W        = 40;
   localparam int TERM_W      = 51;
   localparam int B_W         = 53;
   localparam int HALF_W      = 26;
   localparam int PP_W        = 2 * HALF_W;
   localparam int PROD_W      = 102;
   localparam int REM_W       = PROD_W + 1;
   localparam int SCORE_W     = FRAC_BITS + 1;
   localparam int TOTAL_W     = 36;
   localparam int MAG_W       = 35;
   localparam int COUNT_W     = 19;
   localparam int MEAN_W      = 18;
   localparam int CNT_W       = 6;
   localparam int MUL_STEPS   = 4;
   localparam int DIV_STEPS   = FRAC_BITS;
   localparam int MDIV_STEPS  = MAG_W;

   localparam logic [CSR_IDX_W-1:0] REG_PLANE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_CLASS  = 2'd2;

   localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_10 = 2'd1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

   typedef struct packed {
      logic [SUM_W-1:0] sx;
      logic [SUM_W-1:0] sy;
      logic [SQ_W-1:0]  sxx;
      logic [SQ_W-1:0]  syy;
      logic [SQ_W-1:0]  sxy;
   } win_sums_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_ACC,
      OP_SQ,
      OP_LIN,
      OP_CON,
      OP_MUL,
      OP_DIVI,
      OP_DIV,
      OP_SCORE,
      OP_MINIT,
      OP_MDIV,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [CNT_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic win_end;
      logic plane_end;
      logic out_free;
   } dp_status_type;

   // n^2 * L^2 for the depth class
   function automatic logic [K_W-1:0] k_of(input logic [DEPTH_W-1:0] cls);
      logic [K_W-1:0] k;
      case (cls)
         DEPTH_8:  k = 37'd266342400;
         DEPTH_10: k = 37'd4286582784;
         default:  k = 37'd68685926400;
      endcase
      return k;
   endfunction

   function automatic logic [K9_W-1:0] k9_of(input logic [DEPTH_W-1:0] cls);
      logic [K9_W-1:0] k;
      case (cls)
         DEPTH_8:  k = 40'd2397081600;
         DEPTH_10: k = 40'd38579245056;
         default:  k = 40'd618173337600;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/ssimps_req_if.sv -----
`timescale 1ns / 1ps
// ssimps_req_if: request channel carrying one reference and distorted sample pair
// depends on ssimps_pkg

interface ssimps_req_if;
   logic                                valid;
   logic                                ready;
   logic [ssimps_pkg::SAMPLE_W-1:0]     ref_sample;
   logic [ssimps_pkg::SAMPLE_W-1:0]     dist_sample;

   modport source (output valid, output ref_sample, output dist_sample, input ready);
   modport sink (input valid, input ref_sample, input dist_sample, output ready);
endinterface

// ----- rtl/ssimps_rsp_if.sv -----
`timescale 1ns / 1ps
// ssimps_rsp_if: result channel carrying the plane mean score
// depends on ssimps_pkg

interface ssimps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssimps_pkg::MEAN_W-1:0] mean_ssim;
   logic [ssimps_pkg::COUNT_W-1:0]      window_count;
   logic                                plane_valid;

   modport source (output valid, output mean_ssim, output window_count,
                   output plane_valid, input ready);
   modport sink (input valid, input mean_ssim, input window_count,
                 input plane_valid, output ready);
endinterface

// ----- rtl/ssimps_ctrl.sv -----
`timescale 1ns / 1ps
// ssimps_ctrl: sequencer for sample accumulation, window scoring and plane mean
// depends on ssimps_pkg; drives ssimps_dp through a command struct

module ssimps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ssimps_pkg::dp_status_type status,
   output ssimps_pkg::dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_ACC   = 12'b0000_0000_0010,
      S_SQ    = 12'b0000_0000_0100,
      S_LIN   = 12'b0000_0000_1000,
      S_CON   = 12'b0000_0001_0000,
      S_MUL   = 12'b0000_0010_0000,
      S_DIVI  = 12'b0000_0100_0000,
      S_DIV   = 12'b0000_1000_0000,
      S_SCORE = 12'b0001_0000_0000,
      S_MINIT = 12'b0010_0000_0000,
      S_MDIV  = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [ssimps_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd.op    = ssimps_pkg::OP_NOP;
      cmd.step  = cnt_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ssimps_pkg::OP_LOAD;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.op = ssimps_pkg::OP_ACC;
            if (status.win_end) begin
               state_in = S_SQ;
            end else if (status.plane_end) begin
               state_in = S_MINIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQ: begin
            cmd.op   = ssimps_pkg::OP_SQ;
            state_in = S_LIN;
         end
         S_LIN: begin
            cmd.op   = ssimps_pkg::OP_LIN;
            state_in = S_CON;
         end
         S_CON: begin
            cmd.op   = ssimps_pkg::OP_CON;
            state_in = S_MUL;
            cnt_in   = '0;
         end
         S_MUL: begin
            cmd.op = ssimps_pkg::OP_MUL;
            if (cnt_ff == ssimps_pkg::CNT_W'(ssimps_pkg::MUL_STEPS)) begin
               state_in = S_DIVI;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIVI: begin
            cmd.op   = ssimps_pkg::OP_DIVI;
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cmd.op = ssimps_pkg::OP_DIV;
            if (cnt_ff == ssimps_pkg::CNT_W'(ssimps_pkg::DIV_STEPS - 1)) begin
               state_in = S_SCORE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SCORE: begin
            cmd.op = ssimps_pkg::OP_SCORE;
            if (status.plane_end) begin
               state_in = S_MINIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MINIT: begin
            cmd.op   = ssimps_pkg::OP_MINIT;
            state_in = S_MDIV;
            cnt_in   = '0;
         end
         S_MDIV: begin
            cmd.op = ssimps_pkg::OP_MDIV;
            if (cnt_ff == ssimps_pkg::CNT_W'(ssimps_pkg::MDIV_STEPS - 1)) begin
               state_in = S_OUT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = ssimps_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/ssimps_dp.sv -----
`timescale 1ns / 1ps
// ssimps_dp: column sum memory, window score arithmetic, mean divider and result register
// depends on ssimps_pkg; commanded by ssimps_ctrl

module ssimps_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssimps_pkg::dp_cmd_type                 cmd,
   output ssimps_pkg::dp_status_type              status,
   input  logic [ssimps_pkg::SAMPLE_W-1:0]        req_ref_sample,
   input  logic [ssimps_pkg::SAMPLE_W-1:0]        req_dist_sample,
   input  logic                                   csr_we,
   input  logic [ssimps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssimps_pkg::DIM_W-1:0]           csr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [ssimps_pkg::MEAN_W-1:0]   rsp_mean_ssim,
   output logic [ssimps_pkg::COUNT_W-1:0]         rsp_window_count,
   output logic                                   rsp_plane_valid
);

   localparam int POS_W  = ssimps_pkg::POS_W;
   localparam int DIM_W  = ssimps_pkg::DIM_W;
   localparam int WL     = ssimps_pkg::WIN_LOG;
   localparam int HW     = ssimps_pkg::HALF_W;
   localparam int PW     = ssimps_pkg::PROD_W;
   localparam int TW     = ssimps_pkg::TERM_W;

   // configuration and position
   logic [DIM_W-1:0]                   width_ff, width_in;
   logic [DIM_W-1:0]                   height_ff, height_in;
   logic [ssimps_pkg::DEPTH_W-1:0]     depth_ff, depth_in;
   logic [POS_W-1:0]                   col_ff, col_in;
   logic [POS_W-1:0]                   line_ff, line_in;
   logic [DIM_W-1:0]                   w_eff, h_eff;
   logic                               col_last;

   // sample stage
   logic [ssimps_pkg::SAMPLE_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic [ssimps_pkg::COL_AW-1:0]      addr_ff, addr_in;
   logic                               acc_en_ff, acc_en_in;
   logic                               first_ff, first_in;
   logic                               win_end_ff, win_end_in;
   logic                               plane_end_ff, plane_end_in;
   ssimps_pkg::win_sums_type           mem [ssimps_pkg::NCOLS];
   ssimps_pkg::win_sums_type           rd_ff;
   ssimps_pkg::win_sums_type           base, new_sums;
   ssimps_pkg::win_sums_type           s_ff, s_in;

   // window score
   logic [ssimps_pkg::PAIR_W-1:0]      pxy_ff, pxy_in, pxx_ff, pxx_in, pyy_ff, pyy_in;
   logic [TW-1:0]                      a_ff, a_in, c_ff, c_in;
   logic signed [ssimps_pkg::VAR_W-1:0] t_ff, t_in;
   logic [ssimps_pkg::VAR_W-1:0]       vv_ff, vv_in;
   logic signed [ssimps_pkg::B_W-1:0]  b_val;
   logic [ssimps_pkg::B_W-1:0]         b_abs;
   logic [TW-1:0]                      bmag_ff, bmag_in, d_ff, d_in;
   logic                               bneg_ff, bneg_in;
   logic [HW-1:0]                      ap, bp, cp, dp;
   logic [ssimps_pkg::PP_W-1:0]        prod_n_ff, prod_n_in, prod_d_ff, prod_d_in;
   logic [1:0]                         sh_ff, sh_in;
   logic [PW-1:0]                      pn_ff, pn_in, pd_ff, pd_in;
   logic [ssimps_pkg::REM_W-1:0]       rem_ff, rem_in, r2;
   logic                               ge;
   logic [ssimps_pkg::DIV_STEPS-1:0]   q_ff, q_in;
   logic                               sat_ff, sat_in;
   logic [ssimps_pkg::SCORE_W-1:0]     score_mag;
   logic [ssimps_pkg::TOTAL_W-1:0]     score_ext;

   // plane mean
   logic signed [ssimps_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [ssimps_pkg::TOTAL_W-1:0]     total_abs;
   logic [ssimps_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [ssimps_pkg::MAG_W-1:0]       mq_ff, mq_in;
   logic [ssimps_pkg::COUNT_W-1:0]     mrem_ff, mrem_in;
   logic [ssimps_pkg::COUNT_W:0]       rn, rn_sub;
   logic                               mge;
   logic                               mneg_ff, mneg_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ssimps_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic [ssimps_pkg::COUNT_W-1:0]     wcount_ff, wcount_in;
   logic                               pvalid_ff, pvalid_in;

   function automatic logic [PW-1:0] pp_shift(input logic [ssimps_pkg::PP_W-1:0] p,
                                              input logic [1:0] sh);
      logic [PW+1:0] ext;
      logic [PW+1:0] r;
      ext = (PW + 2)'(p);
      case (sh)
         2'd0:    r = ext;
         2'd1:    r = ext << HW;
         default: r = ext << (2 * HW);
      endcase
      return r[PW-1:0];
   endfunction

   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) :
              (width_ff > DIM_W'(ssimps_pkg::MAX_WIDTH)) ? DIM_W'(ssimps_pkg::MAX_WIDTH) :
              width_ff;
      h_eff = (height_ff == '0) ? DIM_W'(1) :
              (height_ff > DIM_W'(ssimps_pkg::MAX_HEIGHT)) ? DIM_W'(ssimps_pkg::MAX_HEIGHT) :
              height_ff;
      col_last = ({1'b0, col_ff} + DIM_W'(1)) >= w_eff;

      base         = first_ff ? '0 : rd_ff;
      new_sums.sx  = base.sx + ssimps_pkg::SUM_W'(x_ff);
      new_sums.sy  = base.sy + ssimps_pkg::SUM_W'(y_ff);
      new_sums.sxx = base.sxx + ssimps_pkg::SQ_W'(x_ff * x_ff);
      new_sums.syy = base.syy + ssimps_pkg::SQ_W'(y_ff * y_ff);
      new_sums.sxy = base.sxy + ssimps_pkg::SQ_W'(x_ff * y_ff);

      b_val = ssimps_pkg::B_W'(t_ff) * $signed(ssimps_pkg::B_W'(20000))
            + $signed(ssimps_pkg::B_W'(ssimps_pkg::k9_of(depth_ff)));
      b_abs = b_val[ssimps_pkg::B_W-1] ? ssimps_pkg::B_W'(-b_val) : ssimps_pkg::B_W'(b_val);

      ap = cmd.step[1] ? HW'(a_ff[TW-1:HW]) : a_ff[HW-1:0];
      bp = cmd.step[0] ? HW'(bmag_ff[TW-1:HW]) : bmag_ff[HW-1:0];
      cp = cmd.step[1] ? HW'(c_ff[TW-1:HW]) : c_ff[HW-1:0];
      dp = cmd.step[0] ? HW'(d_ff[TW-1:HW]) : d_ff[HW-1:0];

      r2 = {rem_ff[PW-1:0], 1'b0};
      ge = r2 >= {1'b0, pd_ff};

      score_mag = sat_ff ? ssimps_pkg::SCORE_W'(1 << ssimps_pkg::FRAC_BITS) : {1'b0, q_ff};
      score_ext = bneg_ff ? -ssimps_pkg::TOTAL_W'(score_mag) : ssimps_pkg::TOTAL_W'(score_mag);
      total_abs = total_ff[ssimps_pkg::TOTAL_W-1] ? ssimps_pkg::TOTAL_W'(-total_ff)
                                                  : ssimps_pkg::TOTAL_W'(total_ff);

      rn     = {mrem_ff, mq_ff[ssimps_pkg::MAG_W-1]};
      mge    = rn >= {1'b0, count_ff};
      rn_sub = rn - {1'b0, count_ff};
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_in      = addr_ff;
      acc_en_in    = acc_en_ff;
      first_in     = first_ff;
      win_end_in   = win_end_ff;
      plane_end_in = plane_end_ff;
      s_in         = s_ff;
      pxy_in       = pxy_ff;
      pxx_in       = pxx_ff;
      pyy_in       = pyy_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      vv_in        = vv_ff;
      bmag_in      = bmag_ff;
      d_in         = d_ff;
      bneg_in      = bneg_ff;
      prod_n_in    = prod_n_ff;
      prod_d_in    = prod_d_ff;
      sh_in        = sh_ff;
      pn_in        = pn_ff;
      pd_in        = pd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      sat_in       = sat_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      mq_in        = mq_ff;
      mrem_in      = mrem_ff;
      mneg_in      = mneg_ff;
      mean_in      = mean_ff;
      wcount_in    = wcount_ff;
      pvalid_in    = pvalid_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      case (cmd.op)
         ssimps_pkg::OP_LOAD: begin
            x_in       = req_ref_sample;
            y_in       = req_dist_sample;
            addr_in    = col_ff[POS_W-1:WL];
            acc_en_in  = ({1'b0, col_ff[POS_W-1:WL]} < w_eff[DIM_W-1:WL])
                      && ({1'b0, line_ff[POS_W-1:WL]} < h_eff[DIM_W-1:WL]);
            first_in   = (col_ff[WL-1:0] == '0) && (line_ff[WL-1:0] == '0);
            win_end_in = acc_en_in && (col_ff[WL-1:0] == '1) && (line_ff[WL-1:0] == '1);
            plane_end_in = col_last && (({1'b0, line_ff} + DIM_W'(1)) >= h_eff);
            if (col_last) begin
               col_in  = '0;
               line_in = plane_end_in ? '0 : line_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ssimps_pkg::OP_ACC: begin
            if (win_end_ff) begin
               s_in = new_sums;
            end
         end
         ssimps_pkg::OP_SQ: begin
            pxy_in = ssimps_pkg::PAIR_W'(s_ff.sx) * ssimps_pkg::PAIR_W'(s_ff.sy);
            pxx_in = ssimps_pkg::PAIR_W'(s_ff.sx) * ssimps_pkg::PAIR_W'(s_ff.sx);
            pyy_in = ssimps_pkg::PAIR_W'(s_ff.sy) * ssimps_pkg::PAIR_W'(s_ff.sy);
         end
         ssimps_pkg::OP_LIN: begin
            a_in  = TW'(pxy_ff) * TW'(20000) + TW'(ssimps_pkg::k_of(depth_ff));
            c_in  = TW'({1'b0, pxx_ff} + {1'b0, pyy_ff}) * TW'(10000)
                  + TW'(ssimps_pkg::k_of(depth_ff));
            t_in  = $signed({1'b0, s_ff.sxy, 6'd0}) - $signed({1'b0, pxy_ff});
            vv_in = ({1'b0, s_ff.sxx, 6'd0} - {1'b0, pxx_ff})
                  + ({1'b0, s_ff.syy, 6'd0} - {1'b0, pyy_ff});
         end
         ssimps_pkg::OP_CON: begin
            bneg_in = b_val[ssimps_pkg::B_W-1];
            bmag_in = b_abs[TW-1:0];
            d_in    = TW'(vv_ff) * TW'(10000) + TW'(ssimps_pkg::k9_of(depth_ff));
         end
         ssimps_pkg::OP_MUL: begin
            if (cmd.step < ssimps_pkg::CNT_W'(ssimps_pkg::MUL_STEPS)) begin
               prod_n_in = ssimps_pkg::PP_W'(ap) * ssimps_pkg::PP_W'(bp);
               prod_d_in = ssimps_pkg::PP_W'(cp) * ssimps_pkg::PP_W'(dp);
               sh_in     = {1'b0, cmd.step[1]} + {1'b0, cmd.step[0]};
            end
            if (cmd.step == '0) begin
               pn_in = '0;
               pd_in = '0;
            end else begin
               pn_in = pn_ff + pp_shift(prod_n_ff, sh_ff);
               pd_in = pd_ff + pp_shift(prod_d_ff, sh_ff);
            end
         end
         ssimps_pkg::OP_DIVI: begin
            rem_in = {1'b0, pn_ff};
            q_in   = '0;
            sat_in = pn_ff >= pd_ff;
         end
         ssimps_pkg::OP_DIV: begin
            rem_in = ge ? r2 - {1'b0, pd_ff} : r2;
            q_in   = {q_ff[ssimps_pkg::DIV_STEPS-2:0], ge};
         end
         ssimps_pkg::OP_SCORE: begin
            total_in = total_ff + $signed(score_ext);
            count_in = count_ff + 1'b1;
         end
         ssimps_pkg::OP_MINIT: begin
            mq_in   = total_abs[ssimps_pkg::MAG_W-1:0];
            mrem_in = '0;
            mneg_in = total_ff[ssimps_pkg::TOTAL_W-1];
         end
         ssimps_pkg::OP_MDIV: begin
            mrem_in = mge ? rn_sub[ssimps_pkg::COUNT_W-1:0] : rn[ssimps_pkg::COUNT_W-1:0];
            mq_in   = {mq_ff[ssimps_pkg::MAG_W-2:0], mge};
         end
         ssimps_pkg::OP_OUT: begin
            if (count_ff == '0) begin
               mean_in = '0;
            end else if (mneg_ff) begin
               mean_in = -$signed(mq_ff[ssimps_pkg::MEAN_W-1:0]);
            end else begin
               mean_in = $signed(mq_ff[ssimps_pkg::MEAN_W-1:0]);
            end
            wcount_in    = count_ff;
            pvalid_in    = (count_ff != '0);
            rsp_valid_in = 1'b1;
            total_in     = '0;
            count_in     = '0;
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            ssimps_pkg::REG_PLANE_WIDTH:  width_in = csr_data;
            ssimps_pkg::REG_PLANE_HEIGHT: height_in = csr_data;
            ssimps_pkg::REG_DEPTH_CLASS:  depth_in = csr_data[ssimps_pkg::DEPTH_W-1:0];
            default: begin
            end
         endcase
         col_in   = '0;
         line_in  = '0;
         total_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ssimps_pkg::WIDTH_RESET;
         height_ff    <= ssimps_pkg::HEIGHT_RESET;
         depth_ff     <= ssimps_pkg::DEPTH_8;
         col_ff       <= '0;
         line_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      addr_ff      <= addr_in;
      acc_en_ff    <= acc_en_in;
      first_ff     <= first_in;
      win_end_ff   <= win_end_in;
      plane_end_ff <= plane_end_in;
      s_ff         <= s_in;
      pxy_ff       <= pxy_in;
      pxx_ff       <= pxx_in;
      pyy_ff       <= pyy_in;
      a_ff         <= a_in;
      c_ff         <= c_in;
      t_ff         <= t_in;
      vv_ff        <= vv_in;
      bmag_ff      <= bmag_in;
      d_ff         <= d_in;
      bneg_ff      <= bneg_in;
      prod_n_ff    <= prod_n_in;
      prod_d_ff    <= prod_d_in;
      sh_ff        <= sh_in;
      pn_ff        <= pn_in;
      pd_ff        <= pd_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      sat_ff       <= sat_in;
      mq_ff        <= mq_in;
      mrem_ff      <= mrem_in;
      mneg_ff      <= mneg_in;
      mean_ff      <= mean_in;
      wcount_ff    <= wcount_in;
      pvalid_ff    <= pvalid_in;
   end

   // column sum memory: read on request, write back in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.op == ssimps_pkg::OP_LOAD) begin
         rd_ff <= mem[col_ff[POS_W-1:WL]];
      end
      if (cmd.op == ssimps_pkg::OP_ACC && acc_en_ff) begin
         mem[addr_ff] <= new_sums;
      end
   end

   assign status.win_end   = win_end_ff;
   assign status.plane_end = plane_end_ff;
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_ssim    = mean_ff;
   assign rsp_window_count = wcount_ff;
   assign rsp_plane_valid  = pvalid_ff;

endmodule

// ----- rtl/block_ssim_plane_score.sv -----
`timescale 1ns / 1ps
// block_ssim_plane_score: top level of the plane mean ssim scorer over 8x8 windows
// depends on ssimps_pkg, ssimps_req_if, ssimps_rsp_if, ssimps_ctrl and ssimps_dp
//
// req_chan takes one reference/distorted sample pair per request, raster order.
// rsp_chan gives one result after the last sample of the plane: mean score in
// signed Q1.16, the number of whole windows and a plane valid flag.
// csr_* writes plane_width, plane_height and depth_class; any write restarts the
// plane. Write only while the block is idle.
// A request makes a column sum read, then a write back through the memory port.
// The last sample of a window adds the score: 4 partial products per 51 x 51
// bit product and a 16 step divider. The last sample of the plane adds the 35
// step mean divider.
// Reset clears position, totals and the result valid flag and loads the register
// defaults; column sums restart on the first line of each window row.
// A stalled result is held in the output register while requests keep flowing;
// only the next plane result waits for it to drain.

module block_ssim_plane_score (
   input  logic                                 clock,
   input  logic                                 reset,
   ssimps_req_if.sink                           req_chan,
   ssimps_rsp_if.source                         rsp_chan,
   input  logic                                 csr_we,
   input  logic [ssimps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssimps_pkg::DIM_W-1:0]         csr_data
);

   ssimps_pkg::dp_cmd_type    cmd;
   ssimps_pkg::dp_status_type status;

   ssimps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssimps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_ref_sample   (req_chan.ref_sample),
      .req_dist_sample  (req_chan.dist_sample),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_mean_ssim    (rsp_chan.mean_ssim),
      .rsp_window_count (rsp_chan.window_count),
      .rsp_plane_valid  (rsp_chan.plane_valid)
   );

endmodule

// ----- rtl/ssimps_checker.sv -----
`timescale 1ns / 1ps
// ssimps_checker: port level assertions on the plane scorer result channel
// depends on ssimps_pkg; bound to block_ssim_plane_score

module ssimps_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [ssimps_pkg::MEAN_W-1:0]  rsp_mean_ssim,
   input logic [ssimps_pkg::COUNT_W-1:0]        rsp_window_count,
   input logic                                  rsp_plane_valid
);

   // stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_plane_valid == (rsp_window_count != '0)))
      else $error("plane valid disagrees with window count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_plane_valid |-> rsp_mean_ssim == '0)
      else $error("empty plane with nonzero mean");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mean_ssim <= 18'sd65536) && (rsp_mean_ssim >= -18'sd65536))
      else $error("mean out of range");

endmodule

bind block_ssim_plane_score ssimps_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_mean_ssim    (rsp_chan.mean_ssim),
   .rsp_window_count (rsp_chan.window_count),
   .rsp_plane_valid  (rsp_chan.plane_valid)
);
